// File: rtl/console_line_editing_buffer_unit_defines.svh
// assertion macros shared by the line editor rtl
// no dependencies; included inside module bodies after the package import
`ifndef CONSOLE_LINE_EDITING_BUFFER_UNIT_DEFINES_SVH
`define CONSOLE_LINE_EDITING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLBU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("line editor check failed");

// next-cycle implication, checked out of reset
`define CLBU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("line editor check failed");

`endif

// File: rtl/clbu_pkg.sv
// shared constants and types for the console line editor
// no dependencies
package clbu_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EOF   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLIST = 8'h10;
    localparam logic [7:0] CH_KILL  = 8'h15;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic {
        REQ_CHAR = 1'b0,
        REQ_READ = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        RS_NONE      = 3'd0,
        RS_BYTE      = 3'd1,
        RS_EMPTY     = 3'd2,
        RS_EOF_TAKEN = 3'd3,
        RS_EOF_KEPT  = 3'd4
    } rd_status_t;

endpackage

// File: rtl/clbu_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module clbu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/console_line_editing_buffer_unit.sv
// console line editor: ring buffer of typed bytes with read, commit and edit pointers
// uses clbu_pkg, clbu_ram and console_line_editing_buffer_unit_defines.svh
//
// input channel (s_): one request per handshake, either a received character
// (s_req_type 0, s_rx_char) or a reader asking for one byte (s_req_type 1,
// s_read_first set on the first byte of a read call).
// result channel (m_): exactly one result per request, in request order.
// an accepted request is held in the execute stage while the ring memory
// delivers the byte at the read pointer; once the output register is free its
// result is written there and m_valid is set. a new request is taken in the
// same cycle the previous one executes, so while results are taken the block
// sustains one request per cycle; the ring write of a character and the byte
// read of the following request are bypassed when they hit the same entry.
// while m_valid is high and m_ready low a request in the execute stage is held
// and s_ready drops until the result is taken; an empty execute stage still accepts.
// reset clears the three pointers and the execute and output valid flags; ring contents are left
// as they are and no clearing pass is needed.
module console_line_editing_buffer_unit #(
    parameter int BUFFER_DEPTH = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_char,
    input  logic       s_read_first,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_echo_valid,
    output logic [7:0] m_echo_char,
    output logic [7:0] m_erase_count,
    output logic       m_line_commit,
    output logic       m_process_list_request,
    output logic [2:0] m_read_status,
    output logic [7:0] m_read_byte,
    output logic       m_read_line_end
);
    import clbu_pkg::*;
    `include "console_line_editing_buffer_unit_defines.svh"

    localparam int PW = $clog2(2 * BUFFER_DEPTH);
    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam logic [PW:0]   PTR_MOD  = (PW + 1)'(2 * BUFFER_DEPTH);
    localparam logic [PW:0]   DEPTH_W  = (PW + 1)'(BUFFER_DEPTH);
    localparam logic [PW:0]   DEPTH_M1 = (PW + 1)'(BUFFER_DEPTH - 1);
    localparam logic [PW-1:0] PTR_MAX  = PW'(2 * BUFFER_DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P  = PW'(BUFFER_DEPTH);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_MAX) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PTR_MAX : p - PW'(1);
    endfunction

    function automatic logic [PW:0] ptr_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW:0] aw;
        logic [PW:0] bw;
        aw = {1'b0, a};
        bw = {1'b0, b};
        return (aw >= bw) ? aw - bw : aw + PTR_MOD - bw;
    endfunction

    function automatic logic [IW-1:0] ptr_idx(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        q = (p >= DEPTH_P) ? p - DEPTH_P : p;
        return q[IW-1:0];
    endfunction

    function automatic logic [7:0] low_byte(input logic [PW:0] d);
        logic [PW+8:0] w;
        w = (PW + 9)'(d);
        return w[7:0];
    endfunction

    // pointers
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] cp_reg, cp_next;
    logic [PW-1:0] ep_reg, ep_next;

    // execute stage
    logic       a_valid_reg, a_valid_next;
    req_type_t  a_type_reg;
    logic [7:0] a_char_reg;
    logic       a_first_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic       o_echo_valid_reg, o_echo_valid_next;
    logic [7:0] o_echo_char_reg, o_echo_char_next;
    logic [7:0] o_erase_reg, o_erase_next;
    logic       o_commit_reg, o_commit_next;
    logic       o_plist_reg, o_plist_next;
    rd_status_t o_status_reg, o_status_next;
    logic [7:0] o_byte_reg, o_byte_next;
    logic       o_line_end_reg, o_line_end_next;

    logic          a_go;
    logic          s_fire;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [IW-1:0] rd_addr;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_byte;
    logic [7:0]    cc;
    logic [PW:0]   dist_er;

    assign a_go    = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || a_go;
    assign s_fire  = s_valid && s_ready;
    assign rd_byte = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign dist_er = ptr_dist(ep_reg, rp_reg);
    // read address follows the pointer as it leaves the executing request
    assign rd_addr = ptr_idx(rp_next);

    always_comb begin
        rp_next           = rp_reg;
        cp_next           = cp_reg;
        ep_next           = ep_reg;
        wr_en             = 1'b0;
        wr_addr           = ptr_idx(ep_reg);
        cc                = (a_char_reg == CH_CR) ? CH_NL : a_char_reg;
        wr_data           = cc;
        o_echo_valid_next = 1'b0;
        o_echo_char_next  = '0;
        o_erase_next      = '0;
        o_commit_next     = 1'b0;
        o_plist_next      = 1'b0;
        o_status_next     = RS_NONE;
        o_byte_next       = '0;
        o_line_end_next   = 1'b0;
        if (a_go) begin
            if (a_type_reg == REQ_CHAR) begin
                case (a_char_reg)
                    CH_PLIST: begin
                        o_plist_next = 1'b1;
                    end
                    CH_KILL: begin
                        o_erase_next = low_byte(ptr_dist(ep_reg, cp_reg));
                        ep_next      = cp_reg;
                    end
                    CH_BS, CH_DEL: begin
                        if (ep_reg != cp_reg) begin
                            ep_next      = ptr_dec(ep_reg);
                            o_erase_next = 8'd1;
                        end
                    end
                    default: begin
                        if (a_char_reg != CH_NUL && dist_er < DEPTH_W) begin
                            o_echo_valid_next = 1'b1;
                            o_echo_char_next  = cc;
                            wr_en             = 1'b1;
                            ep_next           = ptr_inc(ep_reg);
                            // commit on newline, end-of-file or when the ring fills
                            if (cc == CH_NL || cc == CH_EOF || dist_er == DEPTH_M1) begin
                                cp_next       = ptr_inc(ep_reg);
                                o_commit_next = 1'b1;
                            end
                        end
                    end
                endcase
            end else begin
                if (rp_reg == cp_reg) begin
                    o_status_next = RS_EMPTY;
                end else if (rd_byte == CH_EOF) begin
                    if (a_first_reg) begin
                        rp_next       = ptr_inc(rp_reg);
                        o_status_next = RS_EOF_TAKEN;
                    end else begin
                        o_status_next = RS_EOF_KEPT;
                    end
                end else begin
                    rp_next         = ptr_inc(rp_reg);
                    o_status_next   = RS_BYTE;
                    o_byte_next     = rd_byte;
                    o_line_end_next = (rd_byte == CH_NL);
                end
            end
        end
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_fire) begin
            a_valid_next = 1'b1;
        end else if (a_go) begin
            a_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (a_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rp_reg      <= '0;
            cp_reg      <= '0;
            ep_reg      <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            rp_reg      <= rp_next;
            cp_reg      <= cp_next;
            ep_reg      <= ep_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_type_reg   <= req_type_t'(s_req_type);
            a_char_reg   <= s_rx_char;
            a_first_reg  <= s_read_first;
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
        if (a_go) begin
            o_echo_valid_reg <= o_echo_valid_next;
            o_echo_char_reg  <= o_echo_char_next;
            o_erase_reg      <= o_erase_next;
            o_commit_reg     <= o_commit_next;
            o_plist_reg      <= o_plist_next;
            o_status_reg     <= o_status_next;
            o_byte_reg       <= o_byte_next;
            o_line_end_reg   <= o_line_end_next;
        end
    end

    clbu_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (s_fire),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    assign m_valid                = m_valid_reg;
    assign m_echo_valid           = o_echo_valid_reg;
    assign m_echo_char            = o_echo_char_reg;
    assign m_erase_count          = o_erase_reg;
    assign m_line_commit          = o_commit_reg;
    assign m_process_list_request = o_plist_reg;
    assign m_read_status          = o_status_reg;
    assign m_read_byte            = o_byte_reg;
    assign m_read_line_end        = o_line_end_reg;

    `CLBU_ASSERT_NOW(a_ring_bound, aclk, aresetn, 1'b1, dist_er <= DEPTH_W)
    `CLBU_ASSERT_NOW(a_commit_order, aclk, aresetn, 1'b1,
        ptr_dist(cp_reg, rp_reg) <= dist_er)
    `CLBU_ASSERT_NEXT(a_commit_catches_up, aclk, aresetn, a_go && o_commit_next,
        cp_reg == ep_reg)
    `CLBU_ASSERT_NEXT(a_read_advances, aclk, aresetn,
        a_go && (o_status_next == RS_BYTE || o_status_next == RS_EOF_TAKEN),
        rp_reg != $past(rp_reg))

endmodule

// File: tb/clbu_line_checker.sv
// checker for the console line editor: watches both channels, predicts each result
// depends on clbu_pkg; instantiated beside the block by tb_console_line_editing_buffer_unit
module clbu_line_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_char,
    input  logic       s_read_first,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_echo_valid,
    input  logic [7:0] m_echo_char,
    input  logic [7:0] m_erase_count,
    input  logic       m_line_commit,
    input  logic       m_process_list_request,
    input  logic [2:0] m_read_status,
    input  logic [7:0] m_read_byte,
    input  logic       m_read_line_end,
    output int         mismatches,
    output int         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import clbu_pkg::*;

    localparam int unsigned RING_DEPTH = 128;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_commit;
        logic       plist;
        rd_status_t status;
        logic [7:0] rd_byte;
        logic       line_end;
    } tty_outcome_t;

    // pointers count modulo twice the ring depth, which is the 8-bit wrap here
    logic [7:0]   ring [RING_DEPTH];
    logic [7:0]   rd_ptr;
    logic [7:0]   cm_ptr;
    logic [7:0]   ed_ptr;
    tty_outcome_t tty_outcomes [$];

    function automatic tty_outcome_t apply_request(req_type_t rt, logic [7:0] ch, logic fst);
        tty_outcome_t o;
        logic [7:0]   b;
        o = '0;
        if (rt == REQ_CHAR) begin
            if (ch == CH_PLIST) begin
                o.plist = 1'b1;
            end else if (ch == CH_KILL) begin
                o.erase_count = 8'(ed_ptr - cm_ptr);
                ed_ptr = cm_ptr;
            end else if (ch == CH_BS || ch == CH_DEL) begin
                if (ed_ptr != cm_ptr) begin
                    ed_ptr = ed_ptr - 8'd1;
                    o.erase_count = 8'd1;
                end
            end else if (ch != CH_NUL && 8'(ed_ptr - rd_ptr) < RING_DEPTH) begin
                b = (ch == CH_CR) ? CH_NL : ch;
                o.echo_valid = 1'b1;
                o.echo_char = b;
                ring[ed_ptr[6:0]] = b;
                ed_ptr = ed_ptr + 8'd1;
                // a full ring commits whatever was typed
                if (b == CH_NL || b == CH_EOF || 8'(ed_ptr - rd_ptr) == RING_DEPTH) begin
                    cm_ptr = ed_ptr;
                    o.line_commit = 1'b1;
                end
            end
        end else if (rd_ptr == cm_ptr) begin
            o.status = RS_EMPTY;
        end else begin
            b = ring[rd_ptr[6:0]];
            if (b == CH_EOF) begin
                // eof only goes away when it opens a read call
                if (fst) begin
                    rd_ptr = rd_ptr + 8'd1;
                    o.status = RS_EOF_TAKEN;
                end else begin
                    o.status = RS_EOF_KEPT;
                end
            end else begin
                rd_ptr = rd_ptr + 8'd1;
                o.status = RS_BYTE;
                o.rd_byte = b;
                o.line_end = (b == CH_NL);
            end
        end
        return o;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        tty_outcome_t want;
        if (!aresetn) begin
            rd_ptr <= 8'd0;
            cm_ptr <= 8'd0;
            ed_ptr <= 8'd0;
            tty_outcomes.delete();
            mismatches <= 0;
            outstanding <= 0;
        end else begin
            if (s_valid && s_ready) begin
                tty_outcomes.push_back(apply_request(req_type_t'(s_req_type), s_rx_char,
                                                     s_read_first));
            end
            if (m_valid && m_ready) begin
                if (tty_outcomes.size() == 0) begin
                    $error("result with no request waiting");
                    mismatches++;
                end else begin
                    want = tty_outcomes.pop_front();
                    check_field("echo_valid", want.echo_valid, m_echo_valid);
                    check_field("echo_char", want.echo_char, m_echo_char);
                    check_field("erase_count", want.erase_count, m_erase_count);
                    check_field("line_commit", want.line_commit, m_line_commit);
                    check_field("process_list_request", want.plist, m_process_list_request);
                    check_field("read_status", want.status, m_read_status);
                    check_field("read_byte", want.rd_byte, m_read_byte);
                    check_field("read_line_end", want.line_end, m_read_line_end);
                end
            end
            outstanding <= tty_outcomes.size();
        end
    end

endmodule

// File: tb/tb_console_line_editing_buffer_unit.sv
// top of the line editor testbench: clock, reset, request stimulus, ready stalls, verdict
// depends on clbu_pkg, console_line_editing_buffer_unit and clbu_line_checker
module tb_console_line_editing_buffer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import clbu_pkg::*;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_req_type;
    logic [7:0] s_rx_char;
    logic       s_read_first;
    logic       m_valid;
    logic       m_ready;
    logic       m_echo_valid;
    logic [7:0] m_echo_char;
    logic [7:0] m_erase_count;
    logic       m_line_commit;
    logic       m_process_list_request;
    logic [2:0] m_read_status;
    logic [7:0] m_read_byte;
    logic       m_read_line_end;
    int         mismatches;
    int         outstanding;

    int send_idle_pct;
    int stall_pct;
    int sent;

    console_line_editing_buffer_unit DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_req_type            (s_req_type),
        .s_rx_char             (s_rx_char),
        .s_read_first          (s_read_first),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_echo_valid          (m_echo_valid),
        .m_echo_char           (m_echo_char),
        .m_erase_count         (m_erase_count),
        .m_line_commit         (m_line_commit),
        .m_process_list_request(m_process_list_request),
        .m_read_status         (m_read_status),
        .m_read_byte           (m_read_byte),
        .m_read_line_end       (m_read_line_end)
    );

    clbu_line_checker u_checker (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_req_type            (s_req_type),
        .s_rx_char             (s_rx_char),
        .s_read_first          (s_read_first),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_echo_valid          (m_echo_valid),
        .m_echo_char           (m_echo_char),
        .m_erase_count         (m_erase_count),
        .m_line_commit         (m_line_commit),
        .m_process_list_request(m_process_list_request),
        .m_read_status         (m_read_status),
        .m_read_byte           (m_read_byte),
        .m_read_line_end       (m_read_line_end),
        .mismatches            (mismatches),
        .outstanding           (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("[console_line_editing_buffer_unit] ERROR");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(req_type_t rt, logic [7:0] ch, logic fst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_req_type = rt;
        s_rx_char = ch;
        s_read_first = fst;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(8'h7e, 8'h20));
    endfunction

    function automatic logic [7:0] line_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 72) return printable();
        if (r < 78) return CH_BS;
        if (r < 82) return CH_DEL;
        if (r < 85) return CH_KILL;
        if (r < 87) return CH_PLIST;
        if (r < 89) return CH_NUL;
        return 8'($urandom);
    endfunction

    task automatic type_line();
        int unsigned n;
        int unsigned r;
        n = $urandom_range(12);
        repeat (n) issue(REQ_CHAR, line_char(), 1'($urandom));
        r = $urandom_range(99);
        if (r < 35) issue(REQ_CHAR, CH_CR, 1'($urandom));
        else if (r < 60) issue(REQ_CHAR, CH_NL, 1'($urandom));
        else if (r < 75) issue(REQ_CHAR, CH_EOF, 1'($urandom));
    endtask

    task automatic read_call(int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            issue(REQ_READ, 8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(9) == 0));
        end
    endtask

    // fill the ring to force the full-buffer commit and drops, then empty it
    task automatic fill_ring();
        repeat (130) issue(REQ_CHAR, printable(), 1'($urandom));
        issue(REQ_CHAR, CH_KILL, 1'b0);
        issue(REQ_CHAR, CH_BS, 1'b0);
        read_call(140);
    endtask

    task automatic run_phase(int snd, int rcv, int count, bit with_fill);
        int target;
        int unsigned r;
        send_idle_pct = snd;
        stall_pct = rcv;
        if (with_fill) fill_ring();
        target = sent + count;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 50) type_line();
            else if (r < 88) read_call($urandom_range(1, 16));
            else issue(req_type_t'($urandom_range(1)), 8'($urandom), 1'($urandom));
        end
        drain();
    endtask

    initial begin
        send_idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_CHAR;
        s_rx_char = 8'h00;
        s_read_first = 1'b0;
        m_ready = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty cases, edits, eof handling
        issue(REQ_READ, 8'h00, 1'b1);
        issue(REQ_CHAR, CH_BS, 1'b0);
        issue(REQ_CHAR, CH_KILL, 1'b0);
        issue(REQ_CHAR, CH_NUL, 1'b0);
        issue(REQ_CHAR, CH_PLIST, 1'b1);
        issue(REQ_CHAR, 8'h61, 1'b0);
        issue(REQ_CHAR, 8'hff, 1'b0);
        issue(REQ_CHAR, CH_DEL, 1'b0);
        issue(REQ_CHAR, 8'h80, 1'b1);
        issue(REQ_CHAR, CH_KILL, 1'b0);
        issue(REQ_CHAR, 8'h78, 1'b0);
        issue(REQ_CHAR, CH_CR, 1'b0);
        issue(REQ_READ, 8'hff, 1'b1);
        issue(REQ_READ, 8'h00, 1'b0);
        issue(REQ_READ, 8'h00, 1'b0);
        issue(REQ_CHAR, CH_EOF, 1'b0);
        issue(REQ_READ, 8'h00, 1'b0);
        issue(REQ_READ, 8'h00, 1'b1);
        issue(REQ_CHAR, 8'h71, 1'b0);
        issue(REQ_CHAR, CH_NL, 1'b0);
        issue(REQ_CHAR, CH_BS, 1'b0);
        issue(REQ_READ, 8'h00, 1'b1);
        issue(REQ_READ, 8'h00, 1'b0);
        drain();

        run_phase(0, 0, 60, 1'b0);
        run_phase(72, 0, 60, 1'b0);
        run_phase(0, 72, 20, 1'b1);
        run_phase(17, 17, 60, 1'b0);

        repeat (6) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[console_line_editing_buffer_unit] OK");
        end else begin
            $display("[console_line_editing_buffer_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/clbu_pkg.sv
rtl/clbu_ram.sv
rtl/console_line_editing_buffer_unit.sv
tb/clbu_line_checker.sv
tb/tb_console_line_editing_buffer_unit.sv
